// ===== design/atc_pkg.sv =====
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types and constants for the ARP translation cache.
// ----------------------------------------------------------------------------
package atc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] hw_type;
        logic [31:0] ip_addr;
        logic [47:0] mac_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] mac_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0] hw_type;
        logic [31:0] ip_addr;
        logic [47:0] mac;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic             set_used;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_data;
    } t_tbl_req;

endpackage

// ===== design/atc_table.sv =====
// ----------------------------------------------------------------------------
// atc_table
// Entry storage: 1R1W memory with registered read, plus used flags.
// ----------------------------------------------------------------------------
module atc_table
    import atc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tbl_req i_req,
    output t_entry   o_rd_data,
    output logic     o_rd_used
);

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_used;
    t_entry             r_rd_data;
    logic               r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_req.wr_en && i_req.set_used) begin
                r_used[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_used <= r_used[i_req.rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_used = r_rd_used;

endmodule

// ===== design/atc_match.sv =====
// ----------------------------------------------------------------------------
// atc_match
// Shared compare unit: decides whether one entry satisfies the command.
// ----------------------------------------------------------------------------
module atc_match
    import atc_pkg::*;
(
    input  t_in_item i_item,
    input  t_entry   i_entry,
    input  logic     i_used,
    output logic     o_hit
);

    logic ip_eq;
    logic hw_eq;

    assign ip_eq = (i_entry.ip_addr == i_item.ip_addr);
    assign hw_eq = (i_entry.hw_type == i_item.hw_type);

    always_comb begin
        unique case (i_item.cmd)
            CMD_INSERT: o_hit = !i_used;
            CMD_UPDATE: o_hit = i_used && hw_eq && ip_eq;
            CMD_LOOKUP: o_hit = i_used && ip_eq;
            default:    o_hit = 1'b0;
        endcase
    end

endmodule

// ===== design/atc_ctrl.sv =====
// ----------------------------------------------------------------------------
// atc_ctrl
// Scan sequencer and output register: walks the table one entry per cycle.
// ----------------------------------------------------------------------------
module atc_ctrl
    import atc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    output t_in_item  o_item,
    input  t_entry    i_rd_data,
    input  logic      i_hit,
    output t_tbl_req  o_req
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state,     n_state;
    t_in_item         r_item,      n_item;
    logic [CNT_W-1:0] r_addr,      n_addr;
    logic             r_pend,      n_pend;
    logic [IDX_W-1:0] r_pidx,      n_pidx;
    t_out_item        r_res,       n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,       n_out;

    logic issue;
    logic found;

    assign issue = (r_addr < CNT_W'(ENTRIES));
    assign found = r_pend && i_hit;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        o_req          = '0;
        o_req.rd_idx   = r_addr[IDX_W-1:0];
        o_req.wr_idx   = r_pidx;
        o_req.wr_data  = '{hw_type: r_item.hw_type, ip_addr: r_item.ip_addr,
                           mac: r_item.mac_in};
        o_req.set_used = (r_item.cmd == CMD_INSERT);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_req.rd_en = issue && !found;
                n_pend      = issue;
                n_pidx      = r_addr[IDX_W-1:0];
                if (issue) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (found) begin
                    o_req.wr_en       = (r_item.cmd == CMD_INSERT) ||
                                        (r_item.cmd == CMD_UPDATE);
                    n_res.status      = ST_OK;
                    n_res.mac_out     = (r_item.cmd == CMD_LOOKUP) ? i_rd_data.mac : '0;
                    n_state           = S_DONE;
                end else if (!issue) begin
                    n_res.status  = (r_item.cmd == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
                    n_res.mac_out = '0;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pidx <= n_pidx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_item      = r_item;

endmodule

// ===== design/arp_translation_cache_top.sv =====
// ----------------------------------------------------------------------------
// arp_translation_cache_top
// Table of ARP translations with insert, update and lookup commands.
// ----------------------------------------------------------------------------
// Input channel (i_in_*) carries one command per transfer; output channel
// (o_out_*) returns exactly one result per command, in order.
// Each command scans the table entry by entry through one compare unit,
// one entry per cycle, behind a memory with a registered read. A scan
// ends at the first hit or after the last entry has been compared; the
// result then goes into the output register. The input is ready again
// in the same cycle that the result turns valid, so a new command is
// taken only once the previous one has loaded its result.
// Insert fills the lowest free entry; update rewrites the MAC of the first
// entry matching hardware type and IP; lookup returns the MAC of the first
// entry matching IP. No duplicate check is made.
// Reset marks every entry free and empties the output register; no
// clearing pass is needed.
// While the receiver stalls, the result stays in the output register and
// the next command may be taken and scanned; it waits at the end of its
// scan until the register is free.
// ----------------------------------------------------------------------------
module arp_translation_cache_top
    import atc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_tbl_req req;
    t_entry   rd_data;
    logic     rd_used;
    t_in_item item;
    logic     hit;

    atc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd_data (rd_data),
        .o_rd_used (rd_used)
    );

    atc_match u_match (
        .i_item  (item),
        .i_entry (rd_data),
        .i_used  (rd_used),
        .o_hit   (hit)
    );

    atc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_item      (item),
        .i_rd_data   (rd_data),
        .i_hit       (hit),
        .o_req       (req)
    );

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_mac_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.mac_out == '0)
        else $error("nonzero MAC with failing status");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status == ST_OK || o_out_data.status == ST_FULL ||
                        o_out_data.status == ST_NOTFOUND)
        else $error("illegal status code");

endmodule

// ===== tb/sv/arp_translation_cache_top_test.sv =====
// ----------------------------------------------------------------------------
// arp_translation_cache_top_test
// Self-checking testbench for the ARP translation cache.
// A queue-fed driver offers commands on the input channel. Each transfer
// runs through a local copy of the table, which predicts the status and MAC
// of that command. A monitor compares every output transfer with the oldest
// prediction. A directed pass covers empty-table misses, the unused command,
// extreme fields, duplicate IPs, hardware type mismatch on update and a full
// table. Random phases with varying source/sink idling follow, along with a
// long output stall and a sender pause.
// ----------------------------------------------------------------------------
module arp_translation_cache_top_test;
    import atc_pkg::*;

    localparam int KEYS        = 20;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 200000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    t_in_item  pending_cmds[$];
    t_out_item expected_replies[$];

    logic        tbl_used [ENTRIES] = '{default: 1'b0};
    logic [15:0] tbl_hw   [ENTRIES];
    logic [31:0] tbl_ip   [ENTRIES];
    logic [47:0] tbl_mac  [ENTRIES];

    logic [15:0] key_hw [KEYS];
    logic [31:0] key_ip [KEYS];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_len      = 0;
    bit sender_pause  = 1'b0;
    int fail_count    = 0;
    int cycle_count   = 0;

    arp_translation_cache_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic t_out_item arp_cache_result(input t_in_item c);
        t_out_item r;
        logic      done;
        r.status  = ST_NOTFOUND;
        r.mac_out = '0;
        done      = 1'b0;
        case (c.cmd)
            CMD_INSERT: begin
                r.status = ST_FULL;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && !tbl_used[i]) begin
                        tbl_used[i] = 1'b1;
                        tbl_hw[i]   = c.hw_type;
                        tbl_ip[i]   = c.ip_addr;
                        tbl_mac[i]  = c.mac_in;
                        r.status    = ST_OK;
                        done        = 1'b1;
                    end
                end
            end
            CMD_UPDATE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && tbl_used[i] && tbl_hw[i] == c.hw_type
                            && tbl_ip[i] == c.ip_addr) begin
                        tbl_mac[i] = c.mac_in;
                        r.status   = ST_OK;
                        done       = 1'b1;
                    end
                end
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!done && tbl_used[i] && tbl_ip[i] == c.ip_addr) begin
                        r.mac_out = tbl_mac[i];
                        r.status  = ST_OK;
                        done      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        fail_count++;
        if (fail_count <= 50)
            $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    endtask

    task automatic push_cmd(input logic [1:0] cmd, input logic [15:0] hw,
                            input logic [31:0] ip, input logic [47:0] mac);
        t_in_item c;
        c.cmd     = cmd;
        c.hw_type = hw;
        c.ip_addr = ip;
        c.mac_in  = mac;
        pending_cmds.push_back(c);
    endtask

    function automatic t_in_item random_cmd();
        t_in_item c;
        int       r;
        int       k;
        r                = $urandom_range(0, 99);
        k                = $urandom_range(0, KEYS - 1);
        c.hw_type        = key_hw[k];
        c.ip_addr        = key_ip[k];
        c.mac_in[47:32]  = 16'($urandom);
        c.mac_in[31:0]   = $urandom;
        if (r < 15) begin
            c.cmd = CMD_INSERT;
            if ($urandom_range(0, 3) == 0) begin
                c.hw_type = 16'($urandom);
                c.ip_addr = $urandom;
            end
        end else if (r < 45) begin
            c.cmd = CMD_UPDATE;
            if ($urandom_range(0, 4) == 0)
                c.hw_type = 16'($urandom);
        end else if (r < 92) begin
            c.cmd     = CMD_LOOKUP;
            c.hw_type = 16'($urandom);
            if ($urandom_range(0, 7) == 0)
                c.ip_addr = $urandom;
        end else begin
            c.cmd     = 2'd3;
            c.hw_type = 16'($urandom);
            c.ip_addr = $urandom;
        end
        return c;
    endfunction

    task automatic drain();
        while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n);
        @(negedge clk);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) pending_cmds.push_back(random_cmd());
        drain();
    endtask

    // driver: one transfer per accepted command, prediction at acceptance
    always @(posedge clk) begin : drive_cmds
        logic     took;
        logic     next_valid;
        t_in_item next_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            took       = in_valid && in_ready;
            next_valid = in_valid && !took;
            next_item  = in_data;
            if (took)
                expected_replies.push_back(arp_cache_result(in_data));
            if (!next_valid && !sender_pause && pending_cmds.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                next_item  = pending_cmds.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
            in_data  <= next_item;
        end
    end

    always @(posedge clk) begin : check_replies
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("result with nothing expected", out_data.mac_out, '0);
            end else begin
                want = expected_replies.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 48'(out_data.status), 48'(want.status));
                if (out_data.mac_out !== want.mac_out)
                    report_mismatch("mac_out", out_data.mac_out, want.mac_out);
            end
        end
        out_ready <= hold_len == 0 && $urandom_range(0, 99) >= stall_pct;
    end

    always @(posedge clk) begin
        if (hold_len > 0)
            hold_len <= hold_len - 1;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < KEYS; k++) begin
            key_hw[k] = 16'($urandom);
            key_ip[k] = $urandom;
        end
        key_ip[1] = key_ip[0];
        key_hw[1] = key_hw[0] ^ 16'h0100;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        push_cmd(CMD_LOOKUP, '0, '0, '0);
        push_cmd(CMD_UPDATE, '1, '1, '1);
        push_cmd(2'd3, '1, '1, '1);
        push_cmd(CMD_INSERT, '0, '0, '0);
        push_cmd(CMD_INSERT, '1, '1, '1);
        push_cmd(CMD_LOOKUP, '0, '1, '0);
        push_cmd(CMD_LOOKUP, '1, '0, '1);
        push_cmd(CMD_UPDATE, '1, '1, 48'h0123_4567_89ab);
        push_cmd(CMD_UPDATE, '0, '1, '1);
        push_cmd(CMD_INSERT, 16'h0001, '0, 48'h5555_5555_5555);
        push_cmd(CMD_UPDATE, 16'h0001, '0, 48'haaaa_aaaa_aaaa);
        push_cmd(CMD_LOOKUP, '0, '0, '0);
        for (int k = 0; k < ENTRIES - 3; k++)
            push_cmd(CMD_INSERT, key_hw[k], key_ip[k], {16'($urandom), 32'($urandom)});
        push_cmd(CMD_INSERT, 16'h1234, 32'h0a00_0001, 48'hdead_beef_0001);
        push_cmd(CMD_LOOKUP, '0, key_ip[ENTRIES - 4], '0);
        push_cmd(CMD_LOOKUP, '0, '1, '0);
        drain();

        run_phase(0, 0, PHASE_ITEMS);
        run_phase(80, 0, PHASE_ITEMS);
        run_phase(0, 80, PHASE_ITEMS);
        run_phase(6, 6, PHASE_ITEMS);

        // long sink stall with the source still offering, then a source pause
        @(negedge clk);
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (40) pending_cmds.push_back(random_cmd());
        hold_len <= 300;
        do @(posedge clk); while (hold_len != 0);
        while (pending_cmds.size() > 20) @(posedge clk);
        @(negedge clk);
        sender_pause = 1'b1;
        while (in_valid || expected_replies.size() != 0) @(posedge clk);
        repeat (5) @(negedge clk);
        sender_pause = 1'b0;
        drain();

        repeat (2 * ENTRIES + 8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/atc_pkg.sv
design/atc_table.sv
design/atc_match.sv
design/atc_ctrl.sv
design/arp_translation_cache_top.sv
tb/sv/arp_translation_cache_top_test.sv
